/* design/radial_falloff_kernel_top_defines.svh */
// ---------------------------------------------------------------------------
// Radial falloff kernel assertion macros
// Property wrappers used by the pipeline modules; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef RADIAL_FALLOFF_KERNEL_TOP_DEFINES_SVH
`define RADIAL_FALLOFF_KERNEL_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RFK_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rfk same-cycle check failed");
// next-cycle implication
`define RFK_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rfk next-cycle check failed");
`else
`define RFK_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define RFK_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* design/rfk_pkg.sv */
// ---------------------------------------------------------------------------
// rfk_pkg
// Widths, fixed-point constants, register indexes and stage types.
// ---------------------------------------------------------------------------
package rfk_pkg;

   // field widths
   localparam int ROW_W      = 12;
   localparam int FRAME_W    = 13;
   localparam int CTR_W      = 17;
   localparam int SCL_W      = 16;
   localparam int LEVEL_W    = 17;
   localparam int FRAC_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   // axis term: quotient bits and rounding shifts (den = dim * 2^11)
   localparam int Q_SHIFT    = 11;
   localparam int HALF_SHIFT = 10;
   localparam int QBITS      = 18;
   localparam int TERM_W     = 18;
   localparam logic [TERM_W-1:0] TERM_SAT = 18'd131072;

   // squares and radius
   localparam int SQ_W   = 35;
   localparam logic [SQ_W-1:0] SQ_MAX = 35'd17179869184;
   localparam int SUM_W  = 36;
   localparam int ROOT_W = 18;
   localparam logic [ROOT_W-1:0] ROOT_MAX = 18'd185363;
   localparam int SR_W   = 22;

   // weighted radius and level
   localparam int PR_W     = 35;
   localparam int RW_W     = 23;
   localparam int RW_SHIFT = 12;
   localparam logic [PR_W-1:0]    ROUND_HALF  = 35'd2048;
   localparam logic [RW_W-1:0]    LEVEL_KNEE  = 23'd65529;
   localparam logic [LEVEL_W-1:0] LEVEL_ONE   = 17'd65536;
   localparam logic [LEVEL_W-1:0] LEVEL_FLOOR = 17'd7;

   // register defaults
   localparam logic [FRAME_W-1:0] RST_FRAME  = 13'd256;
   localparam logic [CTR_W-1:0]   RST_CENTER = 17'd32768;
   localparam logic [SCL_W-1:0]   RST_SCALE  = 16'd4096;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 3'd0,
      CSR_FRAME_HEIGHT = 3'd1,
      CSR_CENTER_A     = 3'd2,
      CSR_CENTER_B     = 3'd3,
      CSR_SCALE_A      = 3'd4,
      CSR_SCALE_B      = 3'd5,
      CSR_INV_WEIGHT   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic             valid;
      logic [SUM_W-1:0] sum;
   } sum_beat_type;

   typedef struct packed {
      logic              valid;
      logic [ROOT_W-1:0] root;
   } root_beat_type;

endpackage

/* design/rfk_req_if.sv */
// ---------------------------------------------------------------------------
// rfk_req_if
// Request channel: one cell coordinate per transfer.
// ---------------------------------------------------------------------------
interface rfk_req_if;
   import rfk_pkg::*;

   logic             valid;
   logic             ready;
   logic [ROW_W-1:0] row_index;
   logic [ROW_W-1:0] col_index;

   modport source (output valid, output row_index, output col_index, input ready);
   modport sink   (input valid, input row_index, input col_index, output ready);
endinterface

/* design/rfk_rsp_if.sv */
// ---------------------------------------------------------------------------
// rfk_rsp_if
// Response channel: one falloff level per transfer.
// ---------------------------------------------------------------------------
interface rfk_rsp_if;
   import rfk_pkg::*;

   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] level;

   modport source (output valid, output level, input ready);
   modport sink   (input valid, input level, output ready);
endinterface

/* design/rfk_terms.sv */
// ---------------------------------------------------------------------------
// rfk_terms
// Two axis-term lanes (offset, scale, pipelined divide, saturate, square)
// followed by the sum of squares.
// ---------------------------------------------------------------------------
`include "radial_falloff_kernel_top_defines.svh"

module rfk_terms #(
   parameter int DIM_W = 13
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     advance,
   input  logic                                     in_valid,
   input  logic [1:0][rfk_pkg::ROW_W-1:0]           in_pos,
   input  logic [1:0][DIM_W-1:0]                    dim,
   input  logic [1:0][DIM_W+rfk_pkg::CTR_W-1:0]     cprod,
   input  logic [1:0][rfk_pkg::SCL_W-1:0]           scale,
   output rfk_pkg::sum_beat_type                    out_beat
);
   import rfk_pkg::*;

   localparam int CP_W   = DIM_W + CTR_W;
   localparam int POS_W  = ROW_W + FRAC_W;
   localparam int MAG_W  = (CP_W > POS_W) ? CP_W : POS_W;
   localparam int PROD_W = MAG_W + SCL_W + 1;
   localparam int NQ_W   = PROD_W - Q_SHIFT;
   localparam int REM_W  = DIM_W + QBITS;

   logic             vld0_ff, vld1_ff, vld2_ff, vsq_ff, vsum_ff;
   logic [QBITS:0]   vdiv_ff;

   logic [ROW_W-1:0] pos_ff [2];
   logic [MAG_W-1:0] mag_ff [2];
   logic [NQ_W-1:0]  nq_ff  [2];
   logic [REM_W-1:0] rem_ff [2][QBITS+1];
   logic [QBITS-1:0] q_ff   [2][QBITS+1];
   logic             sat_ff [2][QBITS+1];
   logic [SQ_W-1:0]  sq_ff  [2];
   logic [SUM_W-1:0] sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vdiv_ff <= '0;
         vsq_ff  <= 1'b0;
         vsum_ff <= 1'b0;
      end else if (advance) begin
         vld0_ff <= in_valid;
         vld1_ff <= vld0_ff;
         vld2_ff <= vld1_ff;
         vdiv_ff <= {vdiv_ff[QBITS-1:0], vld2_ff};
         vsq_ff  <= vdiv_ff[QBITS];
         vsum_ff <= vsq_ff;
      end
   end

   for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [MAG_W-1:0]  pext, cext, mag_in;
      logic [PROD_W-1:0] prod;
      logic [NQ_W-1:0]   nq_in;
      logic              sat_in;
      logic [REM_W-1:0]  rem0_in;
      logic [TERM_W-1:0] term;
      logic [SQ_W-1:0]   sq_in;

      always_comb begin
         pext    = MAG_W'({pos_ff[l], {FRAC_W{1'b0}}});
         cext    = MAG_W'(cprod[l]);
         mag_in  = (pext >= cext) ? pext - cext : cext - pext;
         // numerator with half-divisor rounding; the /2048 is exact as a shift
         prod    = PROD_W'(mag_ff[l]) * PROD_W'(scale[l])
                   + (PROD_W'(dim[l]) << HALF_SHIFT);
         nq_in   = NQ_W'(prod >> Q_SHIFT);
         // quotient would not fit QBITS: saturate
         sat_in  = nq_ff[l] >= (NQ_W'(dim[l]) << QBITS);
         rem0_in = REM_W'(nq_ff[l]);
         term    = (sat_ff[l][QBITS] || (q_ff[l][QBITS] > TERM_SAT)) ?
                   TERM_SAT : q_ff[l][QBITS];
         sq_in   = SQ_W'(term) * SQ_W'(term);
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            pos_ff[l]    <= in_pos[l];
            mag_ff[l]    <= mag_in;
            nq_ff[l]     <= nq_in;
            rem_ff[l][0] <= rem0_in;
            q_ff[l][0]   <= '0;
            sat_ff[l][0] <= sat_in;
            sq_ff[l]     <= sq_in;
         end
      end

      // one quotient bit per stage, MSB first
      for (genvar j = 0; j < QBITS; j++) begin : g_div
         localparam int K = QBITS - 1 - j;
         logic [REM_W-1:0] dsh, rem_in;
         logic [QBITS-1:0] q_in;
         logic             take;

         always_comb begin
            dsh    = REM_W'(dim[l]) << K;
            take   = rem_ff[l][j] >= dsh;
            rem_in = take ? rem_ff[l][j] - dsh : rem_ff[l][j];
            q_in   = q_ff[l][j] | (QBITS'(take) << K);
         end

         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[l][j+1] <= rem_in;
               q_ff[l][j+1]   <= q_in;
               sat_ff[l][j+1] <= sat_ff[l][j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sum_ff <= SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]);
      end
   end

   assign out_beat = '{valid: vsum_ff, sum: sum_ff};

   `RFK_ASSERT_NEXT(a_terms_stall_hold, clock, reset, !advance, $stable(vdiv_ff) && $stable(vsum_ff))
   `RFK_ASSERT_IMPLY(a_div_rem_below_dim, clock, reset, vdiv_ff[QBITS], (sat_ff[0][QBITS] || (rem_ff[0][QBITS] < REM_W'(dim[0]))) && (sat_ff[1][QBITS] || (rem_ff[1][QBITS] < REM_W'(dim[1]))))
   `RFK_ASSERT_IMPLY(a_square_in_range, clock, reset, vsq_ff, (sq_ff[0] <= SQ_MAX) && (sq_ff[1] <= SQ_MAX))

endmodule

/* design/rfk_isqrt.sv */
// ---------------------------------------------------------------------------
// rfk_isqrt
// Pipelined integer square root, one root bit per stage (floor result).
// ---------------------------------------------------------------------------
`include "radial_falloff_kernel_top_defines.svh"

module rfk_isqrt (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  rfk_pkg::sum_beat_type  in_beat,
   output rfk_pkg::root_beat_type out_beat
);
   import rfk_pkg::*;

   logic [ROOT_W-1:0] vld_ff;
   logic [SR_W-1:0]   rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [SUM_W-1:0]  v_ff    [ROOT_W-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[ROOT_W-2:0], in_beat.valid};
      end
   end

   for (genvar j = 0; j < ROOT_W; j++) begin : g_step
      localparam int K = ROOT_W - 1 - j;
      logic [SR_W-1:0]   rem_p, remx, trial, rem_in;
      logic [ROOT_W-1:0] root_p, root_in;
      logic [SUM_W-1:0]  v_p;

      if (j == 0) begin : g_first
         assign rem_p  = '0;
         assign root_p = '0;
         assign v_p    = in_beat.sum;
      end else begin : g_next
         assign rem_p  = rem_ff[j-1];
         assign root_p = root_ff[j-1];
         assign v_p    = v_ff[j-1];
      end

      always_comb begin
         remx  = (rem_p << 2) | SR_W'(v_p[2*K+1 -: 2]);
         trial = (SR_W'(root_p) << 2) | SR_W'(1);
         if (remx >= trial) begin
            rem_in  = remx - trial;
            root_in = (root_p << 1) | ROOT_W'(1);
         end else begin
            rem_in  = remx;
            root_in = root_p << 1;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[j]  <= rem_in;
            root_ff[j] <= root_in;
         end
      end

      if (j < ROOT_W - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (advance) begin
               v_ff[j] <= v_p;
            end
         end
      end
   end

   assign out_beat = '{valid: vld_ff[ROOT_W-1], root: root_ff[ROOT_W-1]};

   `RFK_ASSERT_IMPLY(a_sqrt_rem_bound, clock, reset, vld_ff[ROOT_W-1], rem_ff[ROOT_W-1] <= (SR_W'(root_ff[ROOT_W-1]) << 1))
   `RFK_ASSERT_IMPLY(a_sqrt_root_max, clock, reset, vld_ff[ROOT_W-1], root_ff[ROOT_W-1] <= ROOT_MAX)
   `RFK_ASSERT_NEXT(a_sqrt_stall_hold, clock, reset, !advance, $stable(vld_ff))

endmodule

/* design/radial_falloff_kernel_top.sv */
// Pipeline: 44 register stages; a result is loaded into the response register, the last
// of them, and can transfer out from the following edge on.
// Throughput: one transfer per clock unless a waiting response stalls the pipeline; the
// 18-stage divider lanes and the 18-stage square root each retire one bit per stage.
// Reset: synchronous, active high; clears every valid bit and loads register defaults.
// ---------------------------------------------------------------------------
// radial_falloff_kernel_top
// Radial falloff level generator: per cell coordinate, clip(1 - r*w, floor, 1).
// ---------------------------------------------------------------------------
`include "radial_falloff_kernel_top_defines.svh"

module radial_falloff_kernel_top #(
   parameter int MAX_DIM = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   rfk_req_if.sink                          req_ch,
   rfk_rsp_if.source                        rsp_ch,
   input  logic                             csr_wr_en,
   input  logic [rfk_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rfk_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import rfk_pkg::*;

   // clamped dimension needs to hold MAX_DIM itself
   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int CP_W  = DIM_W + CTR_W;

   // Zero dimension reads as 1; anything above MAX_DIM is clamped.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [FRAME_W-1:0] d);
      logic [DIM_W-1:0] r;
      if (d == '0) begin
         r = DIM_W'(1);
      end else if (32'(d) > 32'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = DIM_W'(d);
      end
      return r;
   endfunction

   // -------------------------------------------------------------------
   // Configuration registers. Lane 0 is the row axis (frame width,
   // center a, scale a); lane 1 is the column axis (frame height,
   // center b, scale b). The width/height crossing is intentional.
   // Dimensions are stored already clamped.
   // -------------------------------------------------------------------
   logic [DIM_W-1:0] dim_ff   [2];
   logic [CTR_W-1:0] ctr_ff   [2];
   logic [SCL_W-1:0] scale_ff [2];
   logic [SCL_W-1:0] inv_ff;
   logic [CP_W-1:0]  cprod_ff [2];

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff[0]   <= clamp_dim(RST_FRAME);
         dim_ff[1]   <= clamp_dim(RST_FRAME);
         ctr_ff[0]   <= RST_CENTER;
         ctr_ff[1]   <= RST_CENTER;
         scale_ff[0] <= RST_SCALE;
         scale_ff[1] <= RST_SCALE;
         inv_ff      <= RST_SCALE;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  dim_ff[0]   <= clamp_dim(csr_wdata[FRAME_W-1:0]);
            CSR_FRAME_HEIGHT: dim_ff[1]   <= clamp_dim(csr_wdata[FRAME_W-1:0]);
            CSR_CENTER_A:     ctr_ff[0]   <= csr_wdata[CTR_W-1:0];
            CSR_CENTER_B:     ctr_ff[1]   <= csr_wdata[CTR_W-1:0];
            CSR_SCALE_A:      scale_ff[0] <= csr_wdata[SCL_W-1:0];
            CSR_SCALE_B:      scale_ff[1] <= csr_wdata[SCL_W-1:0];
            CSR_INV_WEIGHT:   inv_ff      <= csr_wdata[SCL_W-1:0];
            default: ;  // indexes past the list are dropped
         endcase
      end
   end

   // Center offset in pixel units at Q.16 (dim * center). Depends on
   // configuration only, so it is registered in the cycle after a write,
   // before any request transferred after the write reaches the offset stage.
   always_ff @(posedge clock) begin
      cprod_ff[0] <= CP_W'(dim_ff[0]) * CP_W'(ctr_ff[0]);
      cprod_ff[1] <= CP_W'(dim_ff[1]) * CP_W'(ctr_ff[1]);
   end

   // -------------------------------------------------------------------
   // Flow control. The whole pipeline moves as one unit. It halts only
   // when the response register holds an untaken result AND the stage
   // behind it is full; bubbles keep squeezing out while the response
   // waits, so requests still transfer in that case.
   // -------------------------------------------------------------------
   logic          advance;
   logic          rw_vld_ff;
   logic          rsp_valid_ff;
   sum_beat_type  sum_beat;
   root_beat_type root_beat;

   assign advance      = !rw_vld_ff || !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;

   logic [1:0][ROW_W-1:0] pos_pk;
   logic [1:0][DIM_W-1:0] dim_pk;
   logic [1:0][CP_W-1:0]  cprod_pk;
   logic [1:0][SCL_W-1:0] scale_pk;

   assign pos_pk   = {req_ch.col_index, req_ch.row_index};
   assign dim_pk   = {dim_ff[1], dim_ff[0]};
   assign cprod_pk = {cprod_ff[1], cprod_ff[0]};
   assign scale_pk = {scale_ff[1], scale_ff[0]};

   // Stages 1..24: input capture, offset, scale, saturation check,
   // 18 divide steps, square, sum of squares.
   rfk_terms #(
      .DIM_W (DIM_W)
   ) u_terms (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_ch.valid),
      .in_pos   (pos_pk),
      .dim      (dim_pk),
      .cprod    (cprod_pk),
      .scale    (scale_pk),
      .out_beat (sum_beat)
   );

   // Stages 25..42: floor square root of the sum of squares.
   rfk_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_beat  (sum_beat),
      .out_beat (root_beat)
   );

   // -------------------------------------------------------------------
   // Stage 43: weighted radius, (r * inv_weight + 0.5) >> 12 in Q.16.
   // -------------------------------------------------------------------
   logic [RW_W-1:0] rw_ff, rw_in;

   assign rw_in = RW_W'((PR_W'(root_beat.root) * PR_W'(inv_ff) + ROUND_HALF) >> RW_SHIFT);

   always_ff @(posedge clock) begin
      if (reset) begin
         rw_vld_ff <= 1'b0;
      end else if (advance) begin
         rw_vld_ff <= root_beat.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rw_ff <= rw_in;
      end
   end

   // -------------------------------------------------------------------
   // Stage 44: response register. level = 1 - rw, floored at 7 (~0.0001).
   // Loads whenever it is empty or its result transfers this edge.
   // -------------------------------------------------------------------
   logic [LEVEL_W-1:0] level_ff, level_in;

   assign level_in = (rw_ff >= LEVEL_KNEE) ? LEVEL_FLOOR
                                           : LEVEL_ONE - LEVEL_W'(rw_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_ch.ready) begin
         rsp_valid_ff <= rw_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_ch.ready) begin
         level_ff <= level_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.level = level_ff;

   `RFK_ASSERT_IMPLY(a_level_range, clock, reset, rsp_valid_ff, (level_ff >= LEVEL_FLOOR) && (level_ff <= LEVEL_ONE))
   `RFK_ASSERT_NEXT(a_rw_stall_hold, clock, reset, rw_vld_ff && !advance, rw_vld_ff && $stable(rw_ff))
   `RFK_ASSERT_NEXT(a_rw_to_rsp, clock, reset, rw_vld_ff && advance, rsp_valid_ff)

endmodule
